// ===== rtl/nsfc_pkg.sv =====
// Shared types, character codes and byte-level functions for the NMEA sentence framer/checker.
`default_nettype none
package nsfc_pkg;

	// Default depth of the classified-byte queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Character codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;

	// Proprietary prefix and talker sentence identifiers
	localparam logic [39:0] PSTM_TEXT = "$PSTM";
	localparam logic [23:0] TAG_GGA = "GGA";
	localparam logic [23:0] TAG_RMC = "RMC";
	localparam logic [23:0] TAG_GSA = "GSA";
	localparam logic [23:0] TAG_GSV = "GSV";
	localparam logic [23:0] TAG_VTG = "VTG";
	localparam logic [23:0] TAG_ZDA = "ZDA";
	localparam logic [23:0] TAG_GST = "GST";

	localparam logic [2:0] PREFIX_LEN = 3'd5;

	typedef enum logic [3:0] {
		TYPE_NONE = 4'd0,
		TYPE_GGA  = 4'd1,
		TYPE_RMC  = 4'd2,
		TYPE_GSA  = 4'd3,
		TYPE_GSV  = 4'd4,
		TYPE_VTG  = 4'd5,
		TYPE_ZDA  = 4'd6,
		TYPE_GST  = 4'd7,
		TYPE_PSTM = 4'd8
	} sent_type_t;

	// One received byte with its class flags, as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       is_dollar;
		logic       is_cr;
		logic       is_lf;
		logic       is_star;
		logic       is_comma;
		logic       hex_ok;
		logic [3:0] hex_val;
	} entry_t;

	// Running sentence state of the back end
	typedef struct packed {
		logic        in_sentence;
		logic        cr_pending;
		logic        star_seen;
		logic [1:0]  hex_chars_taken;
		logic [7:0]  running_xor;
		logic [7:0]  hex_value;
		logic        hex_bad;
		logic [7:0]  byte_count;
		logic [7:0]  comma_count;
		logic        first_field_open;
		logic [1:0]  first_field_len;
		logic [23:0] id_tail;
		logic        prefix_match;
		logic [2:0]  prefix_pos;
	} sent_state_t;

	// Classify one byte
	function automatic entry_t make_entry(input logic [7:0] b);
		entry_t e;
		logic [7:0] dv;
		e.data      = b;
		e.is_dollar = (b == CH_DOLLAR);
		e.is_cr     = (b == CH_CR);
		e.is_lf     = (b == CH_LF);
		e.is_star   = (b == CH_STAR);
		e.is_comma  = (b == CH_COMMA);
		e.hex_ok    = 1'b1;
		dv          = '0;
		if (b >= CH_0 && b <= CH_9) begin
			dv = b - CH_0;
		end else if (b >= CH_UA && b <= CH_UF) begin
			dv = b - CH_UA + 8'd10;
		end else if (b >= CH_LA && b <= CH_LF_HEX) begin
			dv = b - CH_LA + 8'd10;
		end else begin
			e.hex_ok = 1'b0;
		end
		e.hex_val = dv[3:0];
		return e;
	endfunction

	// Expected character of the proprietary prefix at a given position
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = PSTM_TEXT[39:32];
			3'd1:    c = PSTM_TEXT[31:24];
			3'd2:    c = PSTM_TEXT[23:16];
			3'd3:    c = PSTM_TEXT[15:8];
			3'd4:    c = PSTM_TEXT[7:0];
			default: c = '0;
		endcase
		return c;
	endfunction

	// Fold one data byte of an open sentence into the state
	function automatic sent_state_t take_data(input sent_state_t s, input entry_t e);
		sent_state_t n;
		n = s;
		if (s.byte_count != 8'hFF) n.byte_count = s.byte_count + 8'd1;
		if (s.prefix_pos < PREFIX_LEN) begin
			if (e.data != prefix_char(s.prefix_pos)) n.prefix_match = 1'b0;
			n.prefix_pos = s.prefix_pos + 3'd1;
		end
		if (!s.star_seen) begin
			if (e.is_star) begin
				n.star_seen        = 1'b1;
				n.first_field_open = 1'b0;
			end else begin
				n.running_xor = s.running_xor ^ e.data;
				if (e.is_comma) begin
					if (s.comma_count != 8'hFF) n.comma_count = s.comma_count + 8'd1;
					n.first_field_open = 1'b0;
				end else if (s.first_field_open) begin
					n.id_tail = {s.id_tail[15:0], e.data};
					if (s.first_field_len != 2'd3) n.first_field_len = s.first_field_len + 2'd1;
				end
			end
		end else if (s.hex_chars_taken != 2'd2) begin
			if (!e.hex_ok) n.hex_bad = 1'b1;
			else n.hex_value = {s.hex_value[3:0], e.hex_val};
			n.hex_chars_taken = s.hex_chars_taken + 2'd1;
		end
		return n;
	endfunction

	// Talker sentence identifier lookup
	function automatic sent_type_t talker_type(input logic [23:0] tag);
		sent_type_t t;
		case (tag)
			TAG_GGA: t = TYPE_GGA;
			TAG_RMC: t = TYPE_RMC;
			TAG_GSA: t = TYPE_GSA;
			TAG_GSV: t = TYPE_GSV;
			TAG_VTG: t = TYPE_VTG;
			TAG_ZDA: t = TYPE_ZDA;
			TAG_GST: t = TYPE_GST;
			default: t = TYPE_NONE;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/nsfc_if.sv =====
// Valid/ready channel interfaces for received bytes and sentence reports.
`default_nettype none
interface nsfc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfc_report_if;
	logic       valid;
	logic       ready;
	logic       checksum_ok;
	logic       checksum_present;
	logic [7:0] computed_checksum;
	logic [7:0] received_checksum;
	logic       received_hex_ok;
	logic [3:0] sentence_type;
	logic [7:0] field_count;
	logic [7:0] sentence_length;

	modport source (output valid, output checksum_ok, output checksum_present,
		output computed_checksum, output received_checksum, output received_hex_ok,
		output sentence_type, output field_count, output sentence_length, input ready);
	modport sink (input valid, input checksum_ok, input checksum_present,
		input computed_checksum, input received_checksum, input received_hex_ok,
		input sentence_type, input field_count, input sentence_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/nmea_sentence_framer_checker_top.sv =====
// NMEA sentence framer and checksum checker: top level.
//
// rx carries one received character per request (rx_byte). Bytes outside a
// sentence are dropped; a sentence runs from '$' to the first CR LF pair.
// res carries one report per completed sentence: checksum verdict, computed
// and received checksum, field count, length and sentence type.
//
// Throughput: one byte per cycle, sustained while no report waits on res.ready.
// The front end classifies each byte and writes it into a QUEUE_DEPTH-entry
// queue; the back end folds one queued byte per cycle into the running
// sentence state unless a waiting report stalls it. A closing LF is written
// into the queue, then folded by the back end, which loads the report register.
// Reset (arst_n low) clears the queue, the sentence state and the report
// valid flag; any partial sentence is discarded.
// While the receiver holds res.ready low with a report waiting, the back end
// stops, the queue fills and rx.ready falls once it is full.
`default_nettype none
module nmea_sentence_framer_checker_top #(
	parameter int QUEUE_DEPTH = nsfc_pkg::QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	nsfc_byte_if.sink     rx,
	nsfc_report_if.source res
);

	nsfc_pkg::entry_t push_data;
	nsfc_pkg::entry_t pop_data;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;

	nsfc_front u_front (
		.rx        (rx),
		.q_full    (q_full),
		.push_data (push_data),
		.push      (push)
	);

	nsfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	nsfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.res         (res)
	);

endmodule
`default_nettype wire

// ===== rtl/nsfc_front.sv =====
// Front end: takes received bytes and classifies them for the queue.
`default_nettype none
module nsfc_front (
	nsfc_byte_if.sink        rx,
	input  wire logic        q_full,
	output nsfc_pkg::entry_t push_data,
	output logic             push
);

	// Request taken whenever the queue has room
	assign rx.ready  = !q_full;
	assign push      = rx.valid && !q_full;
	assign push_data = nsfc_pkg::make_entry(rx.rx_byte);

endmodule
`default_nettype wire

// ===== rtl/nsfc_queue.sv =====
// Short FIFO of classified bytes between front and back.
`default_nettype none
module nsfc_queue #(
	parameter int DEPTH = nsfc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire nsfc_pkg::entry_t push_data,
	output logic                  full,
	output logic                  not_empty,
	input  wire logic             pop,
	output nsfc_pkg::entry_t      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	nsfc_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PTR_W'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

endmodule
`default_nettype wire

// ===== rtl/nsfc_back.sv =====
// Back end: sentence framing, checksum, field count and type, with the report register.
`default_nettype none
module nsfc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_not_empty,
	input  wire nsfc_pkg::entry_t q_data,
	output logic                  pop,
	nsfc_report_if.source         res
);

	// Idle state after reset
	localparam nsfc_pkg::sent_state_t ST_RESET = '{
		first_field_open: 1'b1,
		prefix_match:     1'b1,
		default:          0
	};

	nsfc_pkg::sent_state_t st_q;
	nsfc_pkg::sent_state_t st_next;
	nsfc_pkg::sent_state_t st_mid;
	nsfc_pkg::sent_state_t st_open;
	nsfc_pkg::sent_type_t  type_now;
	logic                  emit;
	logic                  present;
	logic                  hex_ok;
	logic                  sum_ok;
	logic                  out_valid_q;

	// Back end advances when the queue holds a byte, unless a finished report is still waiting
	assign pop = q_not_empty && (!out_valid_q || res.ready);

	// State of a freshly opened sentence
	always_comb begin
		st_open                  = '0;
		st_open.in_sentence      = 1'b1;
		st_open.byte_count       = 8'd1;
		st_open.first_field_open = 1'b1;
		st_open.prefix_match     = 1'b1;
		st_open.prefix_pos       = 3'd1;
	end

	// Report fields from the current state
	always_comb begin
		present  = st_q.star_seen && (st_q.hex_chars_taken == 2'd2);
		hex_ok   = present && !st_q.hex_bad;
		sum_ok   = hex_ok && (st_q.hex_value == st_q.running_xor);
		type_now = nsfc_pkg::TYPE_NONE;
		if (sum_ok) begin
			if (st_q.prefix_pos == nsfc_pkg::PREFIX_LEN && st_q.prefix_match) begin
				type_now = nsfc_pkg::TYPE_PSTM;
			end else if (st_q.comma_count != 8'd0 && st_q.first_field_len == 2'd3) begin
				type_now = nsfc_pkg::talker_type(st_q.id_tail);
			end
		end
	end

	// Next sentence state; a CR not followed by LF is replayed as data first
	always_comb begin
		st_next = st_q;
		st_mid  = st_q;
		emit    = 1'b0;
		if (!st_q.in_sentence) begin
			if (q_data.is_dollar) st_next = st_open;
		end else if (st_q.cr_pending && q_data.is_lf) begin
			emit                = 1'b1;
			st_next.in_sentence = 1'b0;
			st_next.cr_pending  = 1'b0;
		end else begin
			if (st_q.cr_pending) begin
				st_mid = nsfc_pkg::take_data(st_q, nsfc_pkg::make_entry(nsfc_pkg::CH_CR));
			end
			st_mid.cr_pending = 1'b0;
			if (q_data.is_cr) begin
				st_next            = st_mid;
				st_next.cr_pending = 1'b1;
			end else begin
				st_next = nsfc_pkg::take_data(st_mid, q_data);
			end
		end
	end

	// Sentence state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (pop) begin
			st_q <= st_next;
		end
	end

	// Report valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Report payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res.checksum_ok       <= sum_ok;
			res.checksum_present  <= present;
			res.computed_checksum <= st_q.running_xor;
			res.received_checksum <= hex_ok ? st_q.hex_value : 8'd0;
			res.received_hex_ok   <= hex_ok;
			res.sentence_type     <= 4'(type_now);
			res.field_count       <= (st_q.comma_count != 8'hFF) ?
				st_q.comma_count + 8'd1 : 8'hFF;
			res.sentence_length   <= st_q.byte_count;
		end
	end

	assign res.valid = out_valid_q;

	a_hex_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.star_seen |-> (st_q.hex_chars_taken == 2'd0 && !st_q.hex_bad))
		else $error("hex digits taken before star");

	a_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.prefix_pos <= nsfc_pkg::PREFIX_LEN)
		else $error("prefix position out of range");

	a_report_from_sentence: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (out_valid_q && !st_q.in_sentence))
		else $error("report not raised on sentence close");

	a_type_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.checksum_ok) |-> (res.sentence_type == 4'(nsfc_pkg::TYPE_NONE)))
		else $error("type reported without valid checksum");

endmodule
`default_nettype wire

// ===== bench/nsfc_checker.sv =====
// Sentence checker: follows the byte and report channels, predicts each report and compares.
module nsfc_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	nsfc_byte_if      rx,
	nsfc_report_if    res,
	output int        errors,
	output int        pending,
	output int        reports_seen,
	output int        good_seen
);
	import nsfc_pkg::*;

	// One expected sentence report
	typedef struct packed {
		logic       ok;
		logic       present;
		logic [7:0] calc_sum;
		logic [7:0] rcvd_sum;
		logic       hex_good;
		sent_type_t kind;
		logic [7:0] fields;
		logic [7:0] length;
	} sentence_report_t;

	// Framing state of the sentence being received
	typedef struct packed {
		logic        open;
		logic        cr_wait;
		logic        star;
		logic [1:0]  hex_n;
		logic [7:0]  xsum;
		logic [7:0]  hexv;
		logic        hex_bad;
		logic [7:0]  len;
		logic [7:0]  commas;
		logic        id_open;
		logic [1:0]  id_len;
		logic [23:0] id_last;
		logic        pstm_ok;
		logic [2:0]  pstm_pos;
	} frame_state_t;

	localparam logic [23:0] TALKER_TAGS [7] = '{TAG_GGA, TAG_RMC, TAG_GSA, TAG_GSV,
		TAG_VTG, TAG_ZDA, TAG_GST};

	frame_state_t     fr;
	sentence_report_t awaited[$];

	task automatic report_mismatch(input string msg);
		if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic compare(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("report %0d: %s = %0d, expected %0d",
				reports_seen, name, got, want));
	endtask

	// One data byte of an open sentence
	function automatic void absorb_char(input logic [7:0] c);
		logic [3:0] nib;
		logic       digit;
		if (fr.len != 8'hFF) fr.len++;
		if (fr.pstm_pos < PREFIX_LEN) begin
			if (c != PSTM_TEXT[8 * (4 - int'(fr.pstm_pos)) +: 8]) fr.pstm_ok = 1'b0;
			fr.pstm_pos++;
		end
		if (!fr.star) begin
			if (c == CH_STAR) begin
				fr.star    = 1'b1;
				fr.id_open = 1'b0;
			end else begin
				fr.xsum ^= c;
				if (c == CH_COMMA) begin
					if (fr.commas != 8'hFF) fr.commas++;
					fr.id_open = 1'b0;
				end else if (fr.id_open) begin
					fr.id_last = {fr.id_last[15:0], c};
					if (fr.id_len != 2'd3) fr.id_len++;
				end
			end
		end else if (fr.hex_n != 2'd2) begin
			digit = 1'b1;
			nib   = '0;
			if (c >= CH_0 && c <= CH_9) nib = 4'(c - CH_0);
			else if (c >= CH_UA && c <= CH_UF) nib = 4'(c - CH_UA + 8'd10);
			else if (c >= CH_LA && c <= CH_LF_HEX) nib = 4'(c - CH_LA + 8'd10);
			else digit = 1'b0;
			if (digit) fr.hexv = {fr.hexv[3:0], nib};
			else fr.hex_bad = 1'b1;
			fr.hex_n++;
		end
	endfunction

	// Advance the framer by one accepted byte; returns 1 when a report is due
	function automatic logic feed_byte(input logic [7:0] c, output sentence_report_t r);
		r = '0;
		if (!fr.open) begin
			if (c == CH_DOLLAR) begin
				fr          = '0;
				fr.open     = 1'b1;
				fr.len      = 8'd1;
				fr.id_open  = 1'b1;
				fr.pstm_ok  = 1'b1;
				fr.pstm_pos = 3'd1;
			end
			return 1'b0;
		end
		if (fr.cr_wait) begin
			fr.cr_wait = 1'b0;
			if (c == CH_LF) begin
				r.present  = fr.star && fr.hex_n == 2'd2;
				r.hex_good = r.present && !fr.hex_bad;
				r.ok       = r.hex_good && fr.hexv == fr.xsum;
				r.calc_sum = fr.xsum;
				r.rcvd_sum = r.hex_good ? fr.hexv : 8'd0;
				r.fields   = fr.commas == 8'hFF ? 8'hFF : fr.commas + 8'd1;
				r.length   = fr.len;
				r.kind     = TYPE_NONE;
				if (r.ok) begin
					if (fr.pstm_pos == PREFIX_LEN && fr.pstm_ok) begin
						r.kind = TYPE_PSTM;
					end else if (fr.commas != 0 && fr.id_len == 2'd3) begin
						for (int i = 0; i < 7; i++)
							if (r.kind == TYPE_NONE && TALKER_TAGS[i] == fr.id_last)
								r.kind = sent_type_t'(i + 1);
					end
				end
				fr.open = 1'b0;
				return 1'b1;
			end
			absorb_char(CH_CR);
		end
		if (c == CH_CR) fr.cr_wait = 1'b1;
		else absorb_char(c);
		return 1'b0;
	endfunction

	// Predict on each byte request, compare on each report request
	always @(posedge clk or negedge arst_n) begin : watch
		sentence_report_t want;
		if (!arst_n) begin
			fr         = '0;
			fr.id_open = 1'b1;
			fr.pstm_ok = 1'b1;
			awaited.delete();
			pending <= 0;
		end else begin
			if (rx.valid && rx.ready) begin
				if (feed_byte(rx.rx_byte, want)) awaited.push_back(want);
			end
			if (res.valid && res.ready) begin
				if (awaited.size() == 0) begin
					report_mismatch("report with no sentence outstanding");
				end else begin
					want = awaited.pop_front();
					compare("checksum_ok", 8'(res.checksum_ok), 8'(want.ok));
					compare("checksum_present", 8'(res.checksum_present), 8'(want.present));
					compare("computed_checksum", res.computed_checksum, want.calc_sum);
					compare("received_checksum", res.received_checksum, want.rcvd_sum);
					compare("received_hex_ok", 8'(res.received_hex_ok), 8'(want.hex_good));
					compare("sentence_type", 8'(res.sentence_type), 8'(want.kind));
					compare("field_count", res.field_count, want.fields);
					compare("sentence_length", res.sentence_length, want.length);
					if (want.ok) good_seen++;
				end
				reports_seen++;
			end
			pending <= awaited.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top: clock, reset, byte stimulus, report back-pressure and the verdict.
module tb;
	import nsfc_pkg::*;

	typedef enum {
		TAIL_UPPER, TAIL_LOWER, TAIL_WRONG, TAIL_NONE, TAIL_SHORT, TAIL_BADHEX,
		TAIL_EXTRA, TAIL_OPEN
	} tail_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic quiet  = 1'b0;

	int errors, pending, reports_seen, good_seen;
	int bytes_sent, frames_sent;

	logic [7:0] body_q[$];
	string      tag_names [7] = '{"GGA", "RMC", "GSA", "GSV", "VTG", "ZDA", "GST"};
	string      talkers [4]   = '{"GP", "GN", "GL", "GA"};

	nsfc_byte_if   rx_ch();
	nsfc_report_if res_ch();

	nmea_sentence_framer_checker_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	nsfc_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_ch),
		.res          (res_ch),
		.errors       (errors),
		.pending      (pending),
		.reports_seen (reports_seen),
		.good_seen    (good_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Report receiver: stalls now and then, never during a quiet stretch
	always @(posedge clk) begin
		res_ch.ready <= quiet || ($urandom_range(99) >= 7);
	end

	// Hard stop
	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

	// One byte request, with an occasional gap before it
	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 7) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
	endtask

	// Printable field character, sometimes a high byte; never a framing mark
	function automatic logic [7:0] field_char();
		logic [7:0] c;
		if ($urandom_range(99) < 3) c = 8'($urandom_range(8'h80, 8'hFF));
		else c = 8'($urandom_range(8'h20, 8'h7E));
		if (c == CH_STAR || c == CH_DOLLAR || c == CH_COMMA) c = 8'h2E;
		return c;
	endfunction

	// Hold the sender until every outstanding report has come back
	task automatic drain();
		rx_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// '$', the queued body, then the chosen checksum tail and line end
	task automatic send_frame(input tail_t tail);
		logic [7:0] sum;
		logic [7:0] c;
		sum = '0;
		foreach (body_q[i]) sum ^= body_q[i];
		send_byte(CH_DOLLAR);
		foreach (body_q[i]) send_byte(body_q[i]);
		body_q.delete();
		frames_sent++;
		case (tail)
			TAIL_UPPER, TAIL_EXTRA: send_text($sformatf("*%02X", sum));
			TAIL_LOWER: send_text($sformatf("*%02x", sum));
			TAIL_WRONG: send_text($sformatf("*%02X", sum ^ 8'($urandom_range(1, 255))));
			TAIL_SHORT: begin
				send_byte(CH_STAR);
				if ($urandom_range(1)) send_text($sformatf("%1X", sum[3:0]));
			end
			TAIL_BADHEX: begin
				do c = 8'($urandom_range(0, 255));
				while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
					(c >= CH_LA && c <= CH_LF_HEX) || c == CH_CR);
				send_byte(CH_STAR);
				if ($urandom_range(1)) begin
					send_byte(c);
					send_text("5");
				end else begin
					send_text("5");
					send_byte(c);
				end
			end
			default: ;
		endcase
		// trailing junk after the checksum, sometimes a stray CR
		if (tail == TAIL_EXTRA) begin
			repeat ($urandom_range(1, 4)) send_byte(field_char());
			if ($urandom_range(1)) send_byte(CH_CR);
		end
		if (tail != TAIL_OPEN) send_text("\r\n");
	endtask

	// Random line: mostly well-formed, the rest broken or noise
	task automatic random_sentence();
		int    r;
		int    k;
		tail_t tail;
		r = $urandom_range(99);
		k = $urandom_range(9);
		if (r >= 97) begin
			// long line to push length into saturation
			add_text("GP");
			repeat ($urandom_range(240, 320))
				body_q.push_back($urandom_range(1) ? CH_COMMA : field_char());
			send_frame(TAIL_UPPER);
			return;
		end
		if (r >= 91) begin
			// line noise; a '$' in it may open a sentence of its own
			repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		if (k < 7) begin
			add_text(talkers[$urandom_range(3)]);
			add_text(tag_names[$urandom_range(6)]);
		end else if (k == 7) begin
			add_text("PSTM");
			repeat ($urandom_range(0, 4)) body_q.push_back(8'($urandom_range(CH_UA, 8'h5A)));
		end else begin
			repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom_range(CH_UA, 8'h5A)));
		end
		repeat ($urandom_range(0, 12)) begin
			body_q.push_back(CH_COMMA);
			repeat ($urandom_range(0, 8)) body_q.push_back(field_char());
		end
		// a lone CR or LF, or a second '$', inside the body
		if ($urandom_range(99) < 6)
			body_q.insert($urandom_range(body_q.size()),
				$urandom_range(2) == 0 ? CH_CR : ($urandom_range(1) ? CH_LF : CH_DOLLAR));
		if (r < 40) tail = TAIL_UPPER;
		else if (r < 70) tail = TAIL_LOWER;
		else if (r < 77) tail = TAIL_WRONG;
		else if (r < 81) tail = TAIL_NONE;
		else if (r < 84) tail = TAIL_SHORT;
		else if (r < 87) tail = TAIL_BADHEX;
		else if (r < 90) tail = TAIL_EXTRA;
		else tail = TAIL_OPEN;
		send_frame(tail);
	endtask

	// Stimulus
	initial begin
		int rand_start;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bytes outside any sentence are dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("\r\nA");
		// empty sentence, then a star straight after '$'
		send_frame(TAIL_NONE);
		send_frame(TAIL_UPPER);
		// every talker type, one with lower-case hex
		foreach (tag_names[i]) begin
			add_text({"GP", tag_names[i], ",1,2.5,N"});
			send_frame(i == 1 ? TAIL_LOWER : TAIL_UPPER);
		end
		// proprietary prefix, with and without fields, and over a talker tag
		add_text("PSTMVER,1");
		send_frame(TAIL_UPPER);
		add_text("PSTM");
		send_frame(TAIL_UPPER);
		add_text("PSTMGGA,1");
		send_frame(TAIL_UPPER);
		add_text("PSTX,1");
		send_frame(TAIL_UPPER);
		// tag without a comma, first field too short
		add_text("GPGGA");
		send_frame(TAIL_UPPER);
		add_text("GP,1");
		send_frame(TAIL_UPPER);
		// missing, short, malformed, wrong and over-long checksums
		add_text("GPGGA,1");
		send_frame(TAIL_NONE);
		add_text("GPGSV,3");
		send_frame(TAIL_SHORT);
		add_text("GPVTG,4");
		send_frame(TAIL_BADHEX);
		add_text("GPZDA,5");
		send_frame(TAIL_WRONG);
		add_text("GPGST,6*ZZ");
		send_frame(TAIL_UPPER);
		add_text("GPRMC,7");
		send_frame(TAIL_EXTRA);
		// lone CR, stray LF and a second '$' are plain data
		add_text("GP\nRMC,1\r2,$3");
		send_frame(TAIL_UPPER);
		add_text("$GPGGA,1");
		send_frame(TAIL_UPPER);
		// unterminated line swallows the next '$'
		add_text("GPGSA,2");
		send_frame(TAIL_OPEN);
		add_text("GPGSA,2");
		send_frame(TAIL_UPPER);
		// saturation of comma count and of length
		add_text("GP");
		repeat (300) body_q.push_back(CH_COMMA);
		send_frame(TAIL_UPPER);
		add_text("GPGGA,");
		repeat (260) body_q.push_back(8'h41);
		send_frame(TAIL_UPPER);
		drain();

		// random part
		rand_start = bytes_sent;
		for (int n = 0; bytes_sent - rand_start < 800; n++) begin
			quiet = (n >= 4 && n < 10);
			if (n == 12) drain();
			random_sentence();
		end
		quiet = 1'b0;

		drain();
		repeat (6) @(posedge clk);
		$display("Covered %0d bytes over %0d framed lines, with noise and broken tails.",
			bytes_sent, frames_sent);
		$display("Checked %0d sentence reports, %0d with a matching checksum.",
			reports_seen, good_seen);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
